// ===== sv/assert_macros.svh =====
// assertion macros for the dispatcher rtl
// no dependencies; included by modules that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked every clock, masked while reset is low
`define ASSERT_IMPL(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error(msg);

// next-cycle implication, masked while reset is low
`define ASSERT_NEXT(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error(msg);

`endif

// ===== sv/rdbs_pkg.sv =====
// shared types and constants for the request dispatcher
// used by rdbs_dp, rdbs_ctrl and the top level
`default_nettype none

package rdbs_pkg;

    localparam int MAX_SERVERS_DEF = 16;
    localparam int COUNT_WIDTH_DEF = 20;

    localparam int ARRIVAL_W = 32;
    localparam int WORK_W    = 16;
    localparam int BUSY_W    = 33;
    localparam int SERVER_W  = 4;
    localparam int HANDLED_W = 20;
    localparam int ACT_W     = 5;
    localparam int S_DATA_W  = 48;
    localparam int M_DATA_W  = 32;
    localparam int CMP_W     = 7;

    localparam logic [ACT_W-1:0] ACT_RESET = 5'd16;

    localparam logic KIND_ASSIGN = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    typedef struct packed {
        logic load_req;
        logic cmp;
        logic pick;
        logic update;
        logic sweep_clr;
        logic max_step;
        logic idx_rst;
        logic idx_inc;
        logic load_assign;
        logic load_report;
        logic clear_all;
    } t_dp_cmd;

    typedef struct packed {
        logic ord_ok;
        logic is_final;
        logic best_nz;
        logic idx_end;
        logic match;
        logic idx_last;
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== sv/request_dispatcher_busiest_servers_unit.sv =====
// top level of the round-robin first-free server dispatcher
// depends on rdbs_pkg, rdbs_ctrl and rdbs_dp
//
//  channel  | dir | tdata                                  | tuser | tlast
//  s_axis   | in  | [31:0] arrival_time, [47:32] work_amt  | -     | final_request
//  m_axis   | out | [3:0] server, [4] dropped, [24:5] hdl  | kind  | last_in_run
//  cfg      | in  | wr_data = active_servers (5 bits)      | -     | -
//
// a request is loaded, compared, picked and applied to the tables before its
// result beat; the compare repeats with a subtract while the stored start index
// is not below the effective server count; a final request adds a sweep of those
// servers, report beats up to the last busiest one and a clear; beats wait on tready.
// tready returns after the last result beat, or after the clear cycle on a final.
// reset is synchronous, active low, and clears all server tables at once.
`default_nettype none

module request_dispatcher_busiest_servers_unit import rdbs_pkg::*; #(
    parameter int MAX_SERVERS = MAX_SERVERS_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_wr_en,
    input  wire logic [ACT_W-1:0]    i_cfg_wr_data,
    input  wire logic                i_s_tvalid,
    output logic                     o_s_tready,
    // [31:0] arrival_time, [47:32] work_amount
    input  wire logic [S_DATA_W-1:0] i_s_tdata,
    input  wire logic                i_s_tlast,
    output logic                     o_m_tvalid,
    input  wire logic                i_m_tready,
    // [3:0] server, [4] dropped, [24:5] handled, [31:25] zero
    output logic [M_DATA_W-1:0]      o_m_tdata,
    // [0] kind
    output logic                     o_m_tuser,
    output logic                     o_m_tlast
);

    t_dp_cmd              w_cmd;
    t_dp_stat             w_stat;
    logic [SERVER_W-1:0]  w_server;
    logic                 w_dropped;
    logic [HANDLED_W-1:0] w_handled;

    rdbs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_m_tready (i_m_tready),
        .i_stat     (w_stat),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_cmd      (w_cmd)
    );

    rdbs_dp #(
        .MAX_SERVERS (MAX_SERVERS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_arrival_time  (i_s_tdata[ARRIVAL_W-1:0]),
        .i_work_amount   (i_s_tdata[ARRIVAL_W+WORK_W-1:ARRIVAL_W]),
        .i_final_request (i_s_tlast),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .o_kind          (o_m_tuser),
        .o_server        (w_server),
        .o_dropped       (w_dropped),
        .o_handled       (w_handled),
        .o_last_in_run   (o_m_tlast)
    );

    assign o_m_tdata = {{(M_DATA_W - HANDLED_W - 1 - SERVER_W){1'b0}},
                        w_handled, w_dropped, w_server};

endmodule

`default_nettype wire

// ===== sv/rdbs_dp.sv =====
// datapath: server tables, search, busiest sweep and output register
// depends on rdbs_pkg
`default_nettype none

module rdbs_dp import rdbs_pkg::*; #(
    parameter int MAX_SERVERS = MAX_SERVERS_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_wr_en,
    input  wire logic [ACT_W-1:0]     i_cfg_wr_data,
    input  wire logic [ARRIVAL_W-1:0] i_arrival_time,
    input  wire logic [WORK_W-1:0]    i_work_amount,
    input  wire logic                 i_final_request,
    input  wire t_dp_cmd              i_cmd,
    output t_dp_stat                  o_stat,
    output logic                      o_kind,
    output logic [SERVER_W-1:0]       o_server,
    output logic                      o_dropped,
    output logic [HANDLED_W-1:0]      o_handled,
    output logic                      o_last_in_run
);

    localparam int IW = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
    localparam int KW = $clog2(MAX_SERVERS + 1);

    logic [ACT_W-1:0]       r_active;
    logic [ARRIVAL_W-1:0]   r_arrival;
    logic [WORK_W-1:0]      r_work;
    logic                   r_final;
    logic [BUSY_W-1:0]      r_busy [MAX_SERVERS];
    logic [COUNT_WIDTH-1:0] r_cnt  [MAX_SERVERS];
    logic [IW-1:0]          r_ord;
    logic [MAX_SERVERS-1:0] r_free;
    logic [IW-1:0]          r_chosen;
    logic                   r_found;
    logic [COUNT_WIDTH-1:0] r_best;
    logic [IW-1:0]          r_best_last;
    logic [IW-1:0]          r_idx;
    logic                   r_o_kind;
    logic [SERVER_W-1:0]    r_o_server;
    logic                   r_o_dropped;
    logic [HANDLED_W-1:0]   r_o_handled;
    logic                   r_o_last;

    logic [KW-1:0]          w_k;
    logic [MAX_SERVERS-1:0] w_free;
    logic [IW-1:0]          w_pick_hi;
    logic [IW-1:0]          w_pick_lo;
    logic                   w_any_hi;
    logic                   w_any;
    logic [COUNT_WIDTH-1:0] w_idx_cnt;
    logic [COUNT_WIDTH-1:0] w_sel_cnt;

    // effective server count: zero acts as one, clamp at the table size
    always_comb begin
        if (r_active == '0) begin
            w_k = KW'(1);
        end else if (CMP_W'(r_active) > CMP_W'(MAX_SERVERS)) begin
            w_k = KW'(MAX_SERVERS);
        end else begin
            w_k = KW'(r_active);
        end
    end

    always_comb begin
        for (int i = 0; i < MAX_SERVERS; i++) begin
            w_free[i] = (i < int'(w_k)) && (r_busy[i] <= {1'b0, r_arrival});
        end
    end

    // rotated priority pick: first free at or above start, else lowest free
    always_comb begin
        w_pick_hi = '0;
        w_pick_lo = '0;
        w_any_hi  = 1'b0;
        w_any     = 1'b0;
        for (int i = MAX_SERVERS - 1; i >= 0; i--) begin
            if (r_free[i] && (i >= int'(r_ord))) begin
                w_pick_hi = IW'(i);
                w_any_hi  = 1'b1;
            end
            if (r_free[i]) begin
                w_pick_lo = IW'(i);
                w_any     = 1'b1;
            end
        end
    end

    assign w_idx_cnt = r_cnt[r_idx];
    assign w_sel_cnt = r_cnt[r_chosen];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= ACT_RESET;
            r_ord    <= '0;
            for (int i = 0; i < MAX_SERVERS; i++) begin
                r_busy[i] <= '0;
                r_cnt[i]  <= '0;
            end
        end else begin
            if (i_cfg_wr_en) begin
                r_active <= i_cfg_wr_data;
            end
            // bring a stale start index into range one subtract per cycle
            if (i_cmd.cmp && !o_stat.ord_ok) begin
                r_ord <= r_ord - IW'(w_k);
            end
            if (i_cmd.update) begin
                if (r_found) begin
                    r_busy[r_chosen] <= {1'b0, r_arrival} + BUSY_W'(r_work);
                    if (r_cnt[r_chosen] != '1) begin
                        r_cnt[r_chosen] <= r_cnt[r_chosen] + COUNT_WIDTH'(1);
                    end
                end
                if (CMP_W'(r_ord) + CMP_W'(1) == CMP_W'(w_k)) begin
                    r_ord <= '0;
                end else begin
                    r_ord <= r_ord + IW'(1);
                end
            end
            if (i_cmd.clear_all) begin
                r_ord <= '0;
                for (int i = 0; i < MAX_SERVERS; i++) begin
                    r_busy[i] <= '0;
                    r_cnt[i]  <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_arrival <= i_arrival_time;
            r_work    <= i_work_amount;
            r_final   <= i_final_request;
        end
        if (i_cmd.cmp) begin
            r_free <= w_free;
        end
        if (i_cmd.pick) begin
            r_found  <= w_any;
            r_chosen <= w_any_hi ? w_pick_hi : (w_any ? w_pick_lo : r_ord);
        end
        if (i_cmd.sweep_clr) begin
            r_best      <= '0;
            r_best_last <= '0;
            r_idx       <= '0;
        end
        if (i_cmd.max_step) begin
            if (w_idx_cnt > r_best) begin
                r_best      <= w_idx_cnt;
                r_best_last <= r_idx;
            end else if (w_idx_cnt == r_best) begin
                r_best_last <= r_idx;
            end
        end
        if (i_cmd.idx_rst) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + IW'(1);
        end
        if (i_cmd.load_assign) begin
            r_o_kind    <= KIND_ASSIGN;
            r_o_server  <= SERVER_W'(r_chosen);
            r_o_dropped <= !r_found;
            r_o_handled <= HANDLED_W'(w_sel_cnt);
            r_o_last    <= !(r_final && o_stat.best_nz);
        end
        if (i_cmd.load_report) begin
            r_o_kind    <= KIND_REPORT;
            r_o_server  <= SERVER_W'(r_idx);
            r_o_dropped <= 1'b0;
            r_o_handled <= HANDLED_W'(r_best);
            r_o_last    <= (r_idx == r_best_last);
        end
    end

    always_comb begin
        o_stat.ord_ok   = CMP_W'(r_ord) < CMP_W'(w_k);
        o_stat.is_final = r_final;
        o_stat.best_nz  = (r_best != '0);
        o_stat.idx_end  = (CMP_W'(r_idx) + CMP_W'(1) == CMP_W'(w_k));
        o_stat.match    = (w_idx_cnt == r_best);
        o_stat.idx_last = (r_idx == r_best_last);
    end

    assign o_kind        = r_o_kind;
    assign o_server      = r_o_server;
    assign o_dropped     = r_o_dropped;
    assign o_handled     = r_o_handled;
    assign o_last_in_run = r_o_last;

endmodule

`default_nettype wire

// ===== sv/rdbs_ctrl.sv =====
// controller state machine: sequences search, update, report and clear
// depends on rdbs_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module rdbs_ctrl import rdbs_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_s_tvalid,
    input  wire logic     i_m_tready,
    input  wire t_dp_stat i_stat,
    output logic          o_s_tready,
    output logic          o_m_tvalid,
    output t_dp_cmd       o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CMP,
        S_PICK,
        S_UPD,
        S_MAX,
        S_LDA,
        S_ASGN,
        S_EMIT,
        S_RPT,
        S_CLR
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_s_tready;
    logic   n_s_tready;
    logic   r_m_tvalid;
    logic   n_m_tvalid;
    logic   w_out_beat;

    assign w_out_beat = r_m_tvalid && i_m_tready;

    always_comb begin
        n_state    = r_state;
        n_s_tready = 1'b0;
        n_m_tvalid = r_m_tvalid;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                n_s_tready = 1'b1;
                if (i_s_tvalid && r_s_tready) begin
                    o_cmd.load_req = 1'b1;
                    n_s_tready     = 1'b0;
                    n_state        = S_CMP;
                end
            end
            S_CMP: begin
                o_cmd.cmp = 1'b1;
                if (i_stat.ord_ok) begin
                    n_state = S_PICK;
                end
            end
            S_PICK: begin
                o_cmd.pick = 1'b1;
                n_state    = S_UPD;
            end
            S_UPD: begin
                o_cmd.update = 1'b1;
                if (i_stat.is_final) begin
                    o_cmd.sweep_clr = 1'b1;
                    n_state         = S_MAX;
                end else begin
                    n_state = S_LDA;
                end
            end
            S_MAX: begin
                o_cmd.max_step = 1'b1;
                if (i_stat.idx_end) begin
                    n_state = S_LDA;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_LDA: begin
                o_cmd.load_assign = 1'b1;
                n_m_tvalid        = 1'b1;
                n_state           = S_ASGN;
            end
            S_ASGN: begin
                if (w_out_beat) begin
                    n_m_tvalid = 1'b0;
                    if (i_stat.is_final && i_stat.best_nz) begin
                        o_cmd.idx_rst = 1'b1;
                        n_state       = S_EMIT;
                    end else if (i_stat.is_final) begin
                        n_state = S_CLR;
                    end else begin
                        n_s_tready = 1'b1;
                        n_state    = S_IDLE;
                    end
                end
            end
            S_EMIT: begin
                if (i_stat.match) begin
                    o_cmd.load_report = 1'b1;
                    n_m_tvalid        = 1'b1;
                    n_state           = S_RPT;
                end else if (i_stat.idx_end) begin
                    n_state = S_CLR;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_RPT: begin
                if (w_out_beat) begin
                    n_m_tvalid = 1'b0;
                    if (i_stat.idx_last) begin
                        n_state = S_CLR;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                        n_state       = S_EMIT;
                    end
                end
            end
            S_CLR: begin
                o_cmd.clear_all = 1'b1;
                n_s_tready      = 1'b1;
                n_state         = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_s_tready <= 1'b0;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_s_tready <= n_s_tready;
            r_m_tvalid <= n_m_tvalid;
        end
    end

    assign o_s_tready = r_s_tready;
    assign o_m_tvalid = r_m_tvalid;

    `ASSERT_IMPL(a_valid_in_out_state, i_clk, i_rst_n, r_m_tvalid,
        (r_state == S_ASGN) || (r_state == S_RPT), "result valid outside output state")
    `ASSERT_IMPL(a_ready_excludes_valid, i_clk, i_rst_n, r_s_tready,
        !r_m_tvalid && (r_state == S_IDLE), "input ready while busy")
    `ASSERT_NEXT(a_accept_starts_search, i_clk, i_rst_n, i_s_tvalid && r_s_tready,
        (r_state == S_CMP) && !r_s_tready, "accepted beat did not start a search")

endmodule

`default_nettype wire

// ===== test/tb_request_dispatcher_busiest_servers_unit.sv =====
// self-checking bench for request_dispatcher_busiest_servers_unit
// drives request beats and active_servers writes, predicts each result beat in place
// depends on rdbs_pkg and the dispatcher rtl
module tb_request_dispatcher_busiest_servers_unit;
    import rdbs_pkg::*;

    localparam int RANDOM_ITEMS  = 150;
    localparam int SETTLE_CYCLES = 16;
    localparam int LIMIT_CYCLES  = 400000;

    typedef struct packed {
        logic                 kind;
        logic [SERVER_W-1:0]  server;
        logic                 dropped;
        logic [HANDLED_W-1:0] handled;
        logic                 last;
    } t_dispatch_beat;

    typedef enum logic {ROW_REQ, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind            op;
        logic [ARRIVAL_W-1:0] arr;
        logic [WORK_W-1:0]    work;
        logic                 fin;
        logic [ACT_W-1:0]     act;
        bit                   typed_ok;
        t_dispatch_beat       typed;
    } t_stim_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_wr_en = 1'b0;
    logic [ACT_W-1:0]    i_cfg_wr_data = '0;
    logic                i_s_tvalid = 1'b0;
    logic                o_s_tready;
    logic [S_DATA_W-1:0] i_s_tdata = '0;
    logic                i_s_tlast = 1'b0;
    logic                o_m_tvalid;
    logic                i_m_tready = 1'b0;
    logic [M_DATA_W-1:0] o_m_tdata;
    logic                o_m_tuser;
    logic                o_m_tlast;

    request_dispatcher_busiest_servers_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_s_tvalid    (i_s_tvalid),
        .o_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_s_tlast     (i_s_tlast),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_m_tdata     (o_m_tdata),
        .o_m_tuser     (o_m_tuser),
        .o_m_tlast     (o_m_tlast)
    );

    always #10 i_clk = ~i_clk;

    // mirror of the server tables
    logic [BUSY_W-1:0]    srv_busy  [MAX_SERVERS_DEF];
    logic [HANDLED_W-1:0] srv_count [MAX_SERVERS_DEF];
    logic [SERVER_W-1:0]  srv_ord;
    logic [ACT_W-1:0]     srv_active;

    t_dispatch_beat expected_beats[$];
    t_stim_row      dir_rows[$];
    int             err_count = 0;
    int             cycle_count = 0;
    bit             tx_lazy = 1'b1;
    bit             rx_lazy = 1'b1;
    int             rx_wait = 0;
    t_dispatch_beat got_beat;
    t_dispatch_beat want_beat;

    task automatic queue_beat(input t_dispatch_beat b);
        expected_beats.insert(expected_beats.size(), b);
    endtask

    task automatic add_row(input t_stim_row row);
        dir_rows.insert(dir_rows.size(), row);
    endtask

    task automatic clear_tables();
        int i;
        for (i = 0; i < MAX_SERVERS_DEF; i++) begin
            srv_busy[i]  = '0;
            srv_count[i] = '0;
        end
        srv_ord = '0;
    endtask

    task automatic predict_dispatch(input logic [ARRIVAL_W-1:0] arr,
                                    input logic [WORK_W-1:0] work, input logic fin,
                                    input bit typed_ok, input t_dispatch_beat typed);
        int k, start, pick, i, s;
        bit found;
        logic [HANDLED_W-1:0] best;
        t_dispatch_beat beat;
        if (srv_active == 0)
            k = 1;
        else if (srv_active > MAX_SERVERS_DEF)
            k = MAX_SERVERS_DEF;
        else
            k = int'(srv_active);
        start = int'(srv_ord) % k;
        pick  = start;
        found = 1'b0;
        for (i = 0; i < k && !found; i++) begin
            s = (start + i) % k;
            if (srv_busy[s] <= {1'b0, arr}) begin
                pick  = s;
                found = 1'b1;
            end
        end
        if (found) begin
            srv_busy[pick] = {1'b0, arr} + {{(BUSY_W-WORK_W){1'b0}}, work};
            if (srv_count[pick] != '1)
                srv_count[pick] = srv_count[pick] + 1'b1;
        end
        srv_ord = SERVER_W'((start + 1) % k);

        best = '0;
        if (fin) begin
            for (i = 0; i < k; i++)
                if (srv_count[i] > best)
                    best = srv_count[i];
        end
        beat = '{KIND_ASSIGN, SERVER_W'(pick), !found, srv_count[pick], best == 0};
        queue_beat(typed_ok ? typed : beat);
        if (best != 0) begin
            for (i = 0; i < k; i++)
                if (srv_count[i] == best)
                    queue_beat('{KIND_REPORT, SERVER_W'(i), 1'b0, best, 1'b0});
            expected_beats[expected_beats.size()-1].last = 1'b1;
        end
        if (fin)
            clear_tables();
    endtask

    task automatic send_request(input logic [ARRIVAL_W-1:0] arr,
                                input logic [WORK_W-1:0] work, input logic fin,
                                input bit typed_ok, input t_dispatch_beat typed);
        int gap;
        gap = tx_lazy ? $urandom_range(0, 9) : 0;
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {work, arr};
        i_s_tlast  <= fin;
        do @(posedge i_clk); while (!o_s_tready);
        predict_dispatch(arr, work, fin, typed_ok, typed);
    endtask

    // drain all outstanding beats, then give the clear cycle time to finish
    task automatic settle();
        i_s_tvalid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_active(input logic [ACT_W-1:0] value);
        settle();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        srv_active = value;
    endtask

    function automatic t_stim_row req_row(input logic [ARRIVAL_W-1:0] arr,
                                          input logic [WORK_W-1:0] work, input logic fin);
        return '{ROW_REQ, arr, work, fin, '0, 1'b0, '0};
    endfunction

    function automatic t_stim_row req_typed(input logic [ARRIVAL_W-1:0] arr,
                                            input logic [WORK_W-1:0] work, input logic fin,
                                            input int srv, input logic drop,
                                            input int hdl, input logic last);
        return '{ROW_REQ, arr, work, fin, '0, 1'b1,
                 '{KIND_ASSIGN, SERVER_W'(srv), drop, HANDLED_W'(hdl), last}};
    endfunction

    function automatic t_stim_row cfg_row(input logic [ACT_W-1:0] value);
        return '{ROW_CFG, '0, '0, 1'b0, value, 1'b0, '0};
    endfunction

    task automatic check_field(input string name, input logic [HANDLED_W-1:0] want,
                               input logic [HANDLED_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            err_count++;
        end
    endtask

    // result side: random tready gaps, checked against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                got_beat = '{o_m_tuser, o_m_tdata[3:0], o_m_tdata[4], o_m_tdata[24:5],
                             o_m_tlast};
                if (expected_beats.size() == 0) begin
                    $display("%0t: unexpected beat, expected none, got %p", $time, got_beat);
                    err_count++;
                end else begin
                    want_beat = expected_beats.pop_front();
                    check_field("kind", want_beat.kind, got_beat.kind);
                    check_field("server", want_beat.server, got_beat.server);
                    check_field("dropped", want_beat.dropped, got_beat.dropped);
                    check_field("handled", want_beat.handled, got_beat.handled);
                    check_field("last_in_run", want_beat.last, got_beat.last);
                    check_field("tdata pad", '0, o_m_tdata[31:25]);
                end
                if ($urandom_range(0, 11) == 0)
                    rx_lazy = !rx_lazy;
                rx_wait = rx_lazy ? $urandom_range(0, 9) : 0;
                i_m_tready <= (rx_wait == 0);
            end else if (!i_m_tready) begin
                if (rx_wait <= 1) begin
                    rx_wait = 0;
                    i_m_tready <= 1'b1;
                end else begin
                    rx_wait--;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("%0t: timeout", $time);
            $display("request_dispatcher_busiest_servers_unit verification failed");
            $finish;
        end
    end

    initial begin : stimulus
        int                    r, j, sel, batch_len, rand_sent;
        logic [ARRIVAL_W-1:0]  now_t;
        logic [WORK_W-1:0]     work;
        logic                  fin;
        logic [ACT_W-1:0]      act;

        clear_tables();
        srv_active = ACT_RESET;

        // fresh tables, all 16 servers
        add_row(req_typed(32'd0, 16'd10, 1'b0, 0, 1'b0, 1, 1'b1));
        add_row(req_typed(32'd0, 16'd10, 1'b0, 1, 1'b0, 1, 1'b1));
        add_row(req_typed(32'd5, 16'hFFFF, 1'b0, 2, 1'b0, 1, 1'b1));
        add_row(req_typed(32'd5, 16'd0, 1'b1, 3, 1'b0, 1, 1'b0));
        // single server: busy drop, then free exactly at busy-until
        add_row(cfg_row(5'd1));
        add_row(req_typed(32'd100, 16'd50, 1'b0, 0, 1'b0, 1, 1'b1));
        add_row(req_typed(32'd120, 16'd0, 1'b0, 0, 1'b1, 1, 1'b1));
        add_row(req_typed(32'd150, 16'd0, 1'b0, 0, 1'b0, 2, 1'b1));
        add_row(req_typed(32'd150, 16'd0, 1'b1, 0, 1'b0, 3, 1'b0));
        // zero acts as one server
        add_row(cfg_row(5'd0));
        add_row(req_typed(32'd7, 16'd3, 1'b0, 0, 1'b0, 1, 1'b1));
        add_row(req_typed(32'd8, 16'd0, 1'b0, 0, 1'b1, 1, 1'b1));
        // above the server count acts as 16, state carries over
        add_row(cfg_row(5'd31));
        add_row(req_row(32'd8, 16'd0, 1'b0));
        add_row(req_row(32'hFFFF_FFFF, 16'hFFFF, 1'b0));
        add_row(req_row(32'hFFFF_FFFF, 16'hFFFF, 1'b0));
        // shrink below the stored start index, higher servers drop out of the report
        add_row(cfg_row(5'd2));
        add_row(req_row(32'hFFFF_FFFF, 16'd0, 1'b0));
        add_row(req_row(32'hFFFF_FFFF, 16'd0, 1'b0));
        add_row(req_row(32'hFFFF_FFFF, 16'd0, 1'b1));
        add_row(cfg_row(5'd16));

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (r = 0; r < dir_rows.size(); r++) begin
            if (dir_rows[r].op == ROW_CFG)
                write_active(dir_rows[r].act);
            else
                send_request(dir_rows[r].arr, dir_rows[r].work, dir_rows[r].fin,
                             dir_rows[r].typed_ok, dir_rows[r].typed);
        end

        // random batches, each under a fresh server count
        rand_sent = 0;
        now_t = '0;
        while (rand_sent < RANDOM_ITEMS) begin
            sel = $urandom_range(0, 9);
            case (sel)
                0: act = 5'd0;
                1: act = 5'd1;
                2: act = 5'd16;
                3: act = 5'd31;
                4: act = ACT_W'($urandom_range(17, 31));
                default: act = ACT_W'($urandom_range(1, 16));
            endcase
            write_active(act);
            tx_lazy = ($urandom_range(0, 2) != 0);
            batch_len = $urandom_range(1, 14);
            for (j = 0; j < batch_len; j++) begin
                sel = $urandom_range(0, 19);
                if (sel == 0)
                    now_t = $urandom;
                else if (sel == 1)
                    now_t = 32'hFFFF_FFFF - $urandom_range(0, 300);
                else
                    now_t = now_t + $urandom_range(0, 12);
                sel = $urandom_range(0, 9);
                if (sel == 0)
                    work = WORK_W'($urandom);
                else if (sel == 1)
                    work = '0;
                else
                    work = WORK_W'($urandom_range(1, 40));
                // some batches run on without a final request
                fin = (j == batch_len - 1) && ($urandom_range(0, 3) != 0);
                send_request(now_t, work, fin, 1'b0, '0);
                rand_sent++;
            end
        end

        settle();
        if (err_count == 0 && expected_beats.size() == 0) begin
            $display("request_dispatcher_busiest_servers_unit verification clean");
        end else begin
            $display("request_dispatcher_busiest_servers_unit verification failed");
        end
        $finish;
    end

endmodule

// ===== request_dispatcher_busiest_servers_unit.f =====
+incdir+sv
sv/rdbs_pkg.sv
sv/rdbs_dp.sv
sv/rdbs_ctrl.sv
sv/request_dispatcher_busiest_servers_unit.sv
test/tb_request_dispatcher_busiest_servers_unit.sv
